[rtl/core/tkch_pkg.sv]
// shared types and constants for the top-k count heap
`timescale 1ns / 1ps
package tkch_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CFG_W        = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_EVICTED   = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_POPPED    = 3'd4,
    ST_UNDERFLOW = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_SWIM,
    S_SWIM_CMP,
    S_SINK,
    S_SINK_L,
    S_SINK_R,
    S_FIN
  } state_e;

endpackage

[rtl/core/tkch_ram.sv]
// generic one-write one-read ram with registered read
`timescale 1ns / 1ps
module tkch_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/top_k_count_heap.sv]
// top-k table kept as a binary min-heap on count, entries in one ram
// steps: an upsert scans the held keys, a pop fetches the last entry; then the heap
//   is restored by swim levels (parent read, compare) and sink levels (left child, then
//   right child when present), and the result beat is loaded
// throughput: one item at a time, set by the single ram read port
// reset: table empty, capacity 64, no result pending; ram contents are not cleared
`timescale 1ns / 1ps
module top_k_count_heap #(
  parameter int unsigned CAPACITY = tkch_pkg::CAPACITY_DEF,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [tkch_pkg::DATA_W-1:0] key_i,
  input  logic [tkch_pkg::DATA_W-1:0] count_i,
  input  logic [tkch_pkg::DATA_W-1:0] value_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [tkch_pkg::DATA_W-1:0] out_key_o,
  output logic [tkch_pkg::DATA_W-1:0] out_count_o,
  output logic [tkch_pkg::DATA_W-1:0] out_value_bits_o,
  output logic [CW-1:0]               occupancy_o,
  output logic [tkch_pkg::DATA_W-1:0] min_key_o,
  output logic [tkch_pkg::DATA_W-1:0] min_count_o,
  input  logic                        cfg_we_i,
  input  logic [tkch_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import tkch_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned XW = IW + 2;
  localparam int unsigned EW = (CW > CFG_W) ? CW : CFG_W;

  state_e             state_q, state_d;
  logic [IW-1:0]      pos_q, pos_d;
  entry_t             elem_q, elem_d;
  entry_t             item_q, item_d;
  entry_t             left_q, left_d;
  entry_t             res_q, res_d;
  entry_t             root_q;
  status_e            status_q, status_d;
  logic [CW-1:0]      total_q, total_d;
  logic [CW-1:0]      scan_q, scan_d;
  logic               pend_q, pend_d;
  logic [IW-1:0]      pidx_q, pidx_d;
  logic               ins_q, ins_d;
  logic [CFG_W-1:0]   cap_q;
  logic               ovalid_q;
  logic               load_out;

  status_e            ostat_q;
  entry_t             ores_q;
  logic [CW-1:0]      oocc_q;
  logic [DATA_W-1:0]  omkey_q, omcnt_q;

  logic               we;
  logic [IW-1:0]      waddr, raddr;
  entry_t             wdata, rd;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [XW-1:0]      lw, rw, tot_x;
  logic [IW-1:0]      parent;
  logic [EW-1:0]      eff_cap;
  logic               full;
  logic [CW-1:0]      tot_dec;
  entry_t             child;
  logic [IW-1:0]      cidx;

  tkch_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign rd     = entry_t'(ram_rdata);
  assign lw     = (XW'(pos_q) << 1) + XW'(1);
  assign rw     = lw + XW'(1);
  assign tot_x  = XW'(total_q);
  assign parent = IW'((pos_q - IW'(1)) >> 1);
  assign tot_dec = total_q - CW'(1);

  always_comb begin
    eff_cap = EW'(cap_q);
    if (eff_cap == '0) begin
      eff_cap = EW'(1);
    end
    if (eff_cap > EW'(CAPACITY)) begin
      eff_cap = EW'(CAPACITY);
    end
  end

  assign full = EW'(total_q) >= eff_cap;

  always_comb begin
    if ((state_q == S_SINK_R) && (left_q.count > rd.count)) begin
      child = rd;
      cidx  = IW'(rw);
    end else begin
      child = (state_q == S_SINK_R) ? left_q : rd;
      cidx  = IW'(lw);
    end
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    elem_d   = elem_q;
    item_d   = item_q;
    left_d   = left_q;
    res_d    = res_q;
    status_d = status_q;
    total_d  = total_q;
    scan_d   = scan_q;
    pend_d   = pend_q;
    pidx_d   = pidx_q;
    ins_d    = ins_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = elem_q;
    raddr    = '0;
    load_out = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = '{key: key_i, count: count_i, value: value_bits_i};
          ins_d  = 1'b0;
          if (cmd_i) begin
            if (total_q == '0) begin
              status_d = ST_UNDERFLOW;
              res_d    = '0;
              state_d  = S_FIN;
            end else begin
              status_d = ST_POPPED;
              res_d    = root_q;
              total_d  = tot_dec;
              raddr    = IW'(tot_dec);
              state_d  = (tot_dec == '0) ? S_FIN : S_LAST;
            end
          end else begin
            scan_d  = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_q && (rd.key == item_q.key)) begin
          status_d = ST_UPDATED;
          res_d    = '0;
          elem_d   = item_q;
          pos_d    = pidx_q;
          state_d  = S_SWIM;
        end else if (scan_q < total_q) begin
          raddr  = IW'(scan_q);
          pidx_d = IW'(scan_q);
          scan_d = scan_q + CW'(1);
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else if (full) begin
          if (root_q.count > item_q.count) begin
            status_d = ST_REJECTED;
            res_d    = item_q;
            state_d  = S_FIN;
          end else begin
            status_d = ST_EVICTED;
            res_d    = root_q;
            ins_d    = 1'b1;
            total_d  = tot_dec;
            raddr    = IW'(tot_dec);
            if (tot_dec == '0) begin
              ins_d   = 1'b0;
              elem_d  = item_q;
              pos_d   = '0;
              total_d = CW'(1);
              state_d = S_SWIM;
            end else begin
              state_d = S_LAST;
            end
          end
        end else begin
          status_d = ST_INSERTED;
          res_d    = '0;
          elem_d   = item_q;
          pos_d    = IW'(total_q);
          total_d  = total_q + CW'(1);
          state_d  = S_SWIM;
        end
      end
      S_LAST: begin
        elem_d  = rd;
        pos_d   = '0;
        state_d = S_SINK;
      end
      S_SWIM: begin
        raddr = parent;
        if (pos_q == '0) begin
          state_d = S_SINK;
        end else begin
          state_d = S_SWIM_CMP;
        end
      end
      S_SWIM_CMP: begin
        if (rd.count > elem_q.count) begin
          we      = 1'b1;
          wdata   = rd;
          pos_d   = parent;
          state_d = S_SWIM;
        end else begin
          state_d = S_SINK;
        end
      end
      S_SINK: begin
        raddr = IW'(lw);
        if (lw >= tot_x) begin
          we = 1'b1;
          if (ins_q) begin
            ins_d   = 1'b0;
            elem_d  = item_q;
            pos_d   = IW'(total_q);
            total_d = total_q + CW'(1);
            state_d = S_SWIM;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_SINK_L;
        end
      end
      S_SINK_L, S_SINK_R: begin
        if ((state_q == S_SINK_L) && (rw < tot_x)) begin
          left_d  = rd;
          raddr   = IW'(rw);
          state_d = S_SINK_R;
        end else if (elem_q.count > child.count) begin
          we      = 1'b1;
          wdata   = child;
          pos_d   = cidx;
          state_d = S_SINK;
        end else begin
          we = 1'b1;
          if (ins_q) begin
            ins_d   = 1'b0;
            elem_d  = item_q;
            pos_d   = IW'(total_q);
            total_d = total_q + CW'(1);
            state_d = S_SWIM;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!ovalid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      cap_q    <= CFG_RESET;
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
      ins_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      pend_q  <= pend_d;
      ins_q   <= ins_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    elem_q   <= elem_d;
    item_q   <= item_d;
    left_q   <= left_d;
    res_q    <= res_d;
    status_q <= status_d;
    scan_q   <= scan_d;
    pidx_q   <= pidx_d;
    if (we && (waddr == '0)) begin
      root_q <= wdata;
    end
    if (load_out) begin
      ostat_q <= status_q;
      ores_q  <= res_q;
      oocc_q  <= total_q;
      omkey_q <= (total_q != '0) ? root_q.key : '0;
      omcnt_q <= (total_q != '0) ? root_q.count : '0;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign status_o         = ostat_q;
  assign out_key_o        = ores_q.key;
  assign out_count_o      = ores_q.count;
  assign out_value_bits_o = ores_q.value;
  assign occupancy_o      = oocc_q;
  assign min_key_o        = omkey_q;
  assign min_count_o      = omcnt_q;

endmodule
